/* hdl/trackball_phase_scheduler_top_assert.svh */
// ----------------------------------------------------------------------------
// trackball phase scheduler assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TRACKBALL_PHASE_SCHEDULER_TOP_ASSERT_SVH
`define TRACKBALL_PHASE_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TPS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tps check failed");
// next-cycle implication
`define TPS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tps check failed");
`else
`define TPS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TPS_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* hdl/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg
// shared constants, command and status types of the trackball phase scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

    localparam int LINE_WIDTH_DEF = 10;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int MOVE_W    = 12;
    localparam int RND_W     = 12;
    localparam int RND_SHIFT = 3;
    localparam int GAIN_W    = 16;
    localparam int M_DATA_W  = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd4096;
    localparam logic              ENABLED_RESET = 1'b1;

    localparam logic AXIS_H = 1'b0;
    localparam logic AXIS_V = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL,
        OP_ROUND,
        OP_DIV_MOTION,
        OP_DIV_CATCH,
        OP_DIV_ITER,
        OP_SET_STEP,
        OP_SCHED,
        OP_APPLY,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   axis;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic enabled;
        logic mag_zero;
        logic catch_needed;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/tps_ctrl.sv */
// ----------------------------------------------------------------------------
// tps_ctrl
// sequencer that walks motion words through multiply, round, divide and update
// ----------------------------------------------------------------------------
`default_nettype none

module tps_ctrl #(
    parameter int LINE_WIDTH = tps_pkg::LINE_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tps_pkg::dp_status_t status,
    output tps_pkg::dp_cmd_t         cmd
);

    localparam int CNT_W = $clog2(LINE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_WIDTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_ROUND,
        S_DECIDE,
        S_DIV,
        S_SET_STEP,
        S_SCHED,
        S_CHECK,
        S_APPLY,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic             axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        ready_next = ready_reg;
        cmd.load   = 1'b0;
        cmd.axis   = axis_reg;
        cmd.op     = tps_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                axis_next = tps_pkg::AXIS_H;
                if (status.is_read)
                begin
                    state_next = S_CHECK;
                end
                else if (status.enabled)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.op     = tps_pkg::OP_MUL;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.op     = tps_pkg::OP_ROUND;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.mag_zero)
                begin
                    if (axis_reg == tps_pkg::AXIS_H)
                    begin
                        axis_next  = tps_pkg::AXIS_V;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        ready_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.op     = tps_pkg::OP_DIV_MOTION;
                    cnt_next   = CNT_LAST;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = tps_pkg::OP_DIV_ITER;
                if (cnt_reg == '0)
                begin
                    state_next = status.is_read ? S_APPLY : S_SET_STEP;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_SET_STEP:
            begin
                cmd.op     = tps_pkg::OP_SET_STEP;
                state_next = S_SCHED;
            end
            S_SCHED:
            begin
                cmd.op = tps_pkg::OP_SCHED;
                if (axis_reg == tps_pkg::AXIS_H)
                begin
                    axis_next  = tps_pkg::AXIS_V;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (status.catch_needed)
                begin
                    cmd.op     = tps_pkg::OP_DIV_CATCH;
                    cnt_next   = CNT_LAST;
                    state_next = S_DIV;
                end
                else if (axis_reg == tps_pkg::AXIS_H)
                begin
                    axis_next = tps_pkg::AXIS_V;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_APPLY:
            begin
                cmd.op = tps_pkg::OP_APPLY;
                if (axis_reg == tps_pkg::AXIS_H)
                begin
                    axis_next  = tps_pkg::AXIS_V;
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = tps_pkg::OP_OUT;
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= tps_pkg::AXIS_H;
            cnt_reg   <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire

/* hdl/tps_dp.sv */
// ----------------------------------------------------------------------------
// tps_dp
// axis state, gain multiplier, rounding, shared restoring divider, output word
// ----------------------------------------------------------------------------
`default_nettype none

module tps_dp #(
    parameter int LINE_WIDTH = tps_pkg::LINE_WIDTH_DEF,
    parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tps_pkg::dp_cmd_t                  cmd,
    output tps_pkg::dp_status_t                    status,
    input  wire logic                              command,
    input  wire logic [tps_pkg::MOVE_W-1:0]        move_x,
    input  wire logic [tps_pkg::MOVE_W-1:0]        move_y,
    input  wire logic [LINE_WIDTH-1:0]             frame_lines,
    input  wire logic [LINE_WIDTH-1:0]             scanline,
    input  wire logic [tps_pkg::RND_W-1:0]         random_value,
    input  wire logic                              cfg_we,
    input  wire logic [tps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tps_pkg::M_DATA_W-1:0]           m_tdata
);

    localparam int DELTA_W = tps_pkg::MOVE_W + 1;
    localparam int PROD_W  = DELTA_W + tps_pkg::GAIN_W + 1;
    localparam int V_W     = PROD_W + 1;
    localparam int MAG_W   = V_W - FRAC_BITS;
    localparam int REM_W   = FRAC_BITS + 2;
    localparam int NEXT_W  = LINE_WIDTH + 3;
    localparam int CMP_W   = (MAG_W > LINE_WIDTH + 1) ? MAG_W : LINE_WIDTH + 1;
    localparam int OFS_W   = FRAC_BITS + tps_pkg::RND_W;
    localparam int SPROD_W = LINE_WIDTH + FRAC_BITS;

    localparam logic [NEXT_W-1:0]     NEVER    = '1;
    localparam logic [V_W-1:0]        HALF     = V_W'(1) << (FRAC_BITS - 1);
    localparam logic [LINE_WIDTH-1:0] ONE_LINE = LINE_WIDTH'(1);

    // captured input word
    logic                        cmd_read_reg;
    logic [tps_pkg::MOVE_W-1:0]  move_x_reg;
    logic [tps_pkg::MOVE_W-1:0]  move_y_reg;
    logic [LINE_WIDTH-1:0]       lines_reg;
    logic [LINE_WIDTH-1:0]       scan_reg;
    logic [tps_pkg::RND_W-1:0]   rnd_reg;

    logic [tps_pkg::GAIN_W-1:0]  gain_reg;
    logic                        enabled_reg;

    // per-axis state, index 0 horizontal, 1 vertical
    logic [1:0][1:0]             phase_reg, phase_next;
    logic [1:0]                  dir_reg, dir_next;
    logic [1:0][LINE_WIDTH-1:0]  step_reg, step_next;
    logic [1:0][NEXT_W-1:0]      next_reg, next_next;
    logic [1:0][REM_W-1:0]       rem_reg, rem_next;
    logic [1:0][FRAC_BITS-1:0]   offset_reg, offset_next;

    // working registers
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [MAG_W-1:0]            mag_reg, mag_next;
    logic [LINE_WIDTH-1:0]       div_rem_reg, div_rem_next;
    logic [LINE_WIDTH-1:0]       div_quo_reg, div_quo_next;
    logic [CMP_W-1:0]            div_dvs_reg, div_dvs_next;

    logic                        out_valid_reg, out_valid_next;
    logic [tps_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                        ax;
    logic signed [DELTA_W-1:0]   delta_h, delta_v, delta_sel;
    logic signed [PROD_W-1:0]    prod_calc;
    logic [REM_W-1:0]            rem_sel;
    logic [V_W-1:0]              v_calc, v_abs, mag_sum, cnt_scaled, rem_full;
    logic                        v_neg;
    logic [MAG_W-1:0]            mag_calc;
    logic [OFS_W-1:0]            ofs_sum;
    logic [SPROD_W-1:0]          sched_prod;
    logic [LINE_WIDTH-1:0]       step_sel, step_eff, gap;
    logic [NEXT_W-1:0]           next_sel, next_apply;
    logic [LINE_WIDTH:0]         trial;
    logic [CMP_W-1:0]            trial_ext, trial_diff;
    logic                        trial_ge, r_nz, up;
    logic [1:0]                  n_lo;

    assign ax       = cmd.axis;
    assign rem_sel  = rem_reg[ax];
    assign step_sel = step_reg[ax];
    assign next_sel = next_reg[ax];
    assign step_eff = (step_sel == '0) ? ONE_LINE : step_sel;

    // gain multiply, vertical delta negated
    assign delta_h   = {move_x_reg[tps_pkg::MOVE_W-1], move_x_reg};
    assign delta_v   = -{move_y_reg[tps_pkg::MOVE_W-1], move_y_reg};
    assign delta_sel = (ax == tps_pkg::AXIS_V) ? delta_v : delta_h;
    assign prod_calc = PROD_W'(delta_sel) * PROD_W'($signed({1'b0, gain_reg}));

    // add kept fraction, round half away from zero
    assign v_calc     = {prod_reg[PROD_W-1], prod_reg}
                      + {{(V_W - REM_W){rem_sel[REM_W-1]}}, rem_sel};
    assign v_neg      = v_calc[V_W-1];
    assign v_abs      = v_neg ? (~v_calc + V_W'(1)) : v_calc;
    assign mag_sum    = v_abs + HALF;
    assign mag_calc   = mag_sum[V_W-1:FRAC_BITS];
    assign cnt_scaled = {mag_calc, {FRAC_BITS{1'b0}}};
    assign rem_full   = v_neg ? (v_calc + cnt_scaled) : (v_calc - cnt_scaled);

    assign ofs_sum    = OFS_W'(offset_reg[ax])
                      + OFS_W'(rnd_reg >> tps_pkg::RND_SHIFT);
    assign sched_prod = SPROD_W'(step_sel) * SPROD_W'(offset_reg[ax]);

    // restoring divider, one quotient bit per cycle
    assign trial      = {div_rem_reg, div_quo_reg[LINE_WIDTH-1]};
    assign trial_ext  = CMP_W'(trial);
    assign trial_ge   = trial_ext >= div_dvs_reg;
    assign trial_diff = trial_ext - div_dvs_reg;

    // catch-up
    assign gap        = scan_reg - next_sel[LINE_WIDTH-1:0];
    assign r_nz       = div_rem_reg != '0;
    assign next_apply = NEXT_W'(scan_reg) - NEXT_W'(div_rem_reg)
                      + (r_nz ? NEXT_W'(step_eff) : '0);
    assign n_lo       = div_quo_reg[1:0] + {1'b0, r_nz};
    assign up         = dir_reg[ax] == ax;

    always_comb
    begin
        phase_next     = phase_reg;
        dir_next       = dir_reg;
        step_next      = step_reg;
        next_next      = next_reg;
        rem_next       = rem_reg;
        offset_next    = offset_reg;
        prod_next      = prod_reg;
        mag_next       = mag_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_dvs_next   = div_dvs_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (cmd.op)
            tps_pkg::OP_MUL:
            begin
                prod_next = prod_calc;
            end
            tps_pkg::OP_ROUND:
            begin
                rem_next[ax] = rem_full[REM_W-1:0];
                mag_next     = mag_calc;
                if (mag_calc != '0)
                begin
                    dir_next[ax] = !v_neg;
                end
                else
                begin
                    next_next[ax]   = NEVER;
                    offset_next[ax] = ofs_sum[FRAC_BITS-1:0];
                end
            end
            tps_pkg::OP_DIV_MOTION:
            begin
                div_rem_next = '0;
                div_quo_next = lines_reg;
                div_dvs_next = CMP_W'(mag_reg);
            end
            tps_pkg::OP_DIV_CATCH:
            begin
                div_rem_next = '0;
                div_quo_next = gap;
                div_dvs_next = CMP_W'(step_eff);
            end
            tps_pkg::OP_DIV_ITER:
            begin
                div_rem_next = trial_ge ? trial_diff[LINE_WIDTH-1:0]
                                        : trial[LINE_WIDTH-1:0];
                div_quo_next = {div_quo_reg[LINE_WIDTH-2:0], trial_ge};
            end
            tps_pkg::OP_SET_STEP:
            begin
                step_next[ax] = (div_quo_reg == '0) ? ONE_LINE : div_quo_reg;
            end
            tps_pkg::OP_SCHED:
            begin
                next_next[ax] = NEXT_W'(sched_prod[SPROD_W-1:FRAC_BITS]);
            end
            tps_pkg::OP_APPLY:
            begin
                next_next[ax]  = next_apply;
                phase_next[ax] = up ? (phase_reg[ax] + n_lo) : (phase_reg[ax] - n_lo);
            end
            tps_pkg::OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = tps_pkg::M_DATA_W'({dir_reg[tps_pkg::AXIS_V],
                                                     dir_reg[tps_pkg::AXIS_H],
                                                     phase_reg[tps_pkg::AXIS_V],
                                                     phase_reg[tps_pkg::AXIS_H]});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= tps_pkg::GAIN_RESET;
            enabled_reg   <= tps_pkg::ENABLED_RESET;
            phase_reg     <= '0;
            dir_reg       <= '0;
            step_reg      <= {2{ONE_LINE}};
            next_reg      <= {2{NEVER}};
            rem_reg       <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == tps_pkg::REG_GAIN))
            begin
                gain_reg <= cfg_data[tps_pkg::GAIN_W-1:0];
            end
            if (cfg_we && (cfg_index == tps_pkg::REG_ENABLED))
            begin
                enabled_reg <= cfg_data[0];
            end
            phase_reg     <= phase_next;
            dir_reg       <= dir_next;
            step_reg      <= step_next;
            next_reg      <= next_next;
            rem_reg       <= rem_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_read_reg <= command;
            move_x_reg   <= move_x;
            move_y_reg   <= move_y;
            lines_reg    <= frame_lines;
            scan_reg     <= scanline;
            rnd_reg      <= random_value;
        end
        prod_reg     <= prod_next;
        mag_reg      <= mag_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_dvs_reg  <= div_dvs_next;
        out_data_reg <= out_data_next;
    end

    assign status.is_read      = cmd_read_reg;
    assign status.enabled      = enabled_reg;
    assign status.mag_zero     = mag_reg == '0;
    assign status.catch_needed = (next_sel != NEVER) && (next_sel < NEXT_W'(scan_reg));
    assign status.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/trackball_phase_scheduler_top.sv */
// ----------------------------------------------------------------------------
// trackball_phase_scheduler_top
// Turns per-frame mouse deltas into two-bit trackball phase counters whose
// steps are spread over the scanlines of a frame. A motion word (tuser 0),
// when enabled, scales both deltas by the gain register, rounds, and
// reschedules each axis; it produces no output. A read word (tuser 1) catches
// the counters up to the given scanline and returns one output word. One word
// is processed at a time; axes with nothing to do finish early. The time per
// word is set by the restoring divider, one quotient bit per cycle, shared by
// both axes for lines per step and for the catch-up step count. A pending
// output word does not block the input, but a read that finishes while it is
// still waiting holds in its output state until the earlier word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trackball_phase_scheduler_top_assert.svh"

module trackball_phase_scheduler_top #(
    parameter int LINE_WIDTH = tps_pkg::LINE_WIDTH_DEF,
    parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF,
    localparam int S_FIELD_W = 2 * tps_pkg::MOVE_W + 2 * LINE_WIDTH + tps_pkg::RND_W,
    localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // move_x, move_y, frame_lines, scanline, random_value
    input  wire logic [S_DATA_W-1:0]            s_tdata,
    // command
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // phase_h, phase_v, moving_left, moving_down
    output logic [tps_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tps_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int X_LSB = 0;
    localparam int Y_LSB = X_LSB + tps_pkg::MOVE_W;
    localparam int L_LSB = Y_LSB + tps_pkg::MOVE_W;
    localparam int S_LSB = L_LSB + LINE_WIDTH;
    localparam int R_LSB = S_LSB + LINE_WIDTH;

    tps_pkg::dp_cmd_t    dp_cmd;
    tps_pkg::dp_status_t dp_status;

    logic [tps_pkg::MOVE_W-1:0] move_x;
    logic [tps_pkg::MOVE_W-1:0] move_y;
    logic [LINE_WIDTH-1:0]      frame_lines;
    logic [LINE_WIDTH-1:0]      scanline;
    logic [tps_pkg::RND_W-1:0]  random_value;

    assign move_x       = s_tdata[X_LSB +: tps_pkg::MOVE_W];
    assign move_y       = s_tdata[Y_LSB +: tps_pkg::MOVE_W];
    assign frame_lines  = s_tdata[L_LSB +: LINE_WIDTH];
    assign scanline     = s_tdata[S_LSB +: LINE_WIDTH];
    assign random_value = s_tdata[R_LSB +: tps_pkg::RND_W];

    tps_ctrl #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    tps_dp #(
        .LINE_WIDTH (LINE_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .command      (s_tuser),
        .move_x       (move_x),
        .move_y       (move_y),
        .frame_lines  (frame_lines),
        .scanline     (scanline),
        .random_value (random_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    `TPS_ASSERT_IMP(a_load_only_on_accept, clk, rst_n, dp_cmd.load, s_tvalid && s_tready)
    `TPS_ASSERT_NXT(a_one_word_in_work, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `TPS_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, dp_cmd.op == tps_pkg::OP_OUT, !m_tvalid || m_tready)

endmodule

`default_nettype wire

/* sim/tb_trackball_phase_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trackball_phase_scheduler_top
// self-checking bench, motion and read words in random bursts, stalling output
// ----------------------------------------------------------------------------
module tb_trackball_phase_scheduler_top;

    localparam int LINE_W     = tps_pkg::LINE_WIDTH_DEF;
    localparam int FRAC       = tps_pkg::FRAC_BITS_DEF;
    localparam int MOVE_W     = tps_pkg::MOVE_W;
    localparam int RND_W      = tps_pkg::RND_W;
    localparam int GAIN_W     = tps_pkg::GAIN_W;
    localparam int M_DATA_W   = tps_pkg::M_DATA_W;
    localparam int CFG_IDX_W  = tps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tps_pkg::CFG_DATA_W;
    localparam int NEXT_W     = LINE_W + 3;
    localparam int S_W        = ((2 * MOVE_W + 2 * LINE_W + RND_W + 7) / 8) * 8;

    localparam logic CMD_MOTION = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [LINE_W+2:0] NEVER_LINE  = '1;
    localparam longint            HALF_Q      = 64'sd1 <<< (FRAC - 1);
    localparam longint            ONE_Q       = 64'sd1 <<< FRAC;
    localparam int unsigned       CYCLE_LIMIT = 1_000_000;
    localparam int                SETTLE      = 64;

    typedef struct packed {
        logic              cmd;
        logic [MOVE_W-1:0] move_x;
        logic [MOVE_W-1:0] move_y;
        logic [LINE_W-1:0] frame_lines;
        logic [LINE_W-1:0] scanline;
        logic [RND_W-1:0]  rnd;
    } trackball_word_t;

    localparam int WORD_W = $bits(trackball_word_t);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // move_x, move_y, frame_lines, scanline, random_value
    logic [S_W-1:0]        s_tdata = '0;
    // command
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // phase_h, phase_v, moving_left, moving_down
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    trackball_phase_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model of the scheduler, indexed by axis code
    logic [GAIN_W-1:0] gain_q = tps_pkg::GAIN_RESET;
    logic              en_q = tps_pkg::ENABLED_RESET;
    logic [1:0]        phase_q [2] = '{2'd0, 2'd0};
    logic              dir_q [2] = '{1'b0, 1'b0};
    logic [LINE_W-1:0] step_q [2] = '{10'd1, 10'd1};
    logic [LINE_W+2:0] next_q [2] = '{NEVER_LINE, NEVER_LINE};
    longint            rem_q [2] = '{64'sd0, 64'sd0};
    logic [FRAC-1:0]   off_q [2] = '{12'd0, 12'd0};

    trackball_word_t pending_words [$];
    logic [5:0]      expected_phases [$];
    trackball_word_t drive_word;
    logic [5:0]      want;
    logic            word_taken = 1'b0;
    int unsigned     burst_left = 0;
    int unsigned     gap_left = 0;
    int unsigned     ready_cnt = 0;
    int unsigned     cycles = 0;
    int unsigned     mismatches = 0;
    int unsigned     motion_words = 0;
    int unsigned     ignored_words = 0;
    int unsigned     read_words = 0;
    int unsigned     phase_steps = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void rescale_axis(input logic ax, input longint delta,
                                         input logic [LINE_W-1:0] lines,
                                         input logic [RND_W-1:0] rnd);
        longint acc;
        longint cnt;
        longint mag;
        longint quo;
        longint off;
        acc = delta * longint'(gain_q) + rem_q[ax];
        if (acc >= 0)
            cnt = (acc + HALF_Q) >>> FRAC;
        else
            cnt = -((-acc + HALF_Q) >>> FRAC);
        rem_q[ax] = acc - cnt * ONE_Q;
        if (cnt != 0)
        begin
            dir_q[ax] = (cnt > 0);
            mag = (cnt > 0) ? cnt : -cnt;
            quo = longint'(lines) / mag;
            if (quo == 0)
                quo = 1;
            step_q[ax] = quo[LINE_W-1:0];
            next_q[ax] = NEXT_W'((longint'(step_q[ax]) * longint'(off_q[ax])) >>> FRAC);
        end
        else
        begin
            // idle axis: no steps scheduled, offset drifts by up to an eighth
            next_q[ax] = NEVER_LINE;
            off = ((longint'(off_q[ax]) <<< 3) + longint'(rnd)) >>> 3;
            off_q[ax] = off[FRAC-1:0];
        end
    endfunction

    function automatic int unsigned advance_axis(input logic ax,
                                                 input logic [LINE_W-1:0] line);
        int unsigned stp;
        int unsigned l;
        int unsigned nx;
        int unsigned n;
        if (next_q[ax] == NEVER_LINE || next_q[ax] >= line)
            return 0;
        stp = (step_q[ax] == '0) ? 32'd1 : 32'(step_q[ax]);
        l = 32'(line);
        nx = 32'(next_q[ax]);
        n = (l - nx + stp - 1) / stp;
        next_q[ax] = NEXT_W'(nx + n * stp);
        if (dir_q[ax] == (ax == tps_pkg::AXIS_V))
            phase_q[ax] = phase_q[ax] + n[1:0];
        else
            phase_q[ax] = phase_q[ax] - n[1:0];
        return n;
    endfunction

    function automatic void push_motion(input logic [MOVE_W-1:0] x, input logic [MOVE_W-1:0] y,
                                        input logic [LINE_W-1:0] lines,
                                        input logic [RND_W-1:0] rnd);
        trackball_word_t w;
        w.cmd = CMD_MOTION;
        w.move_x = x;
        w.move_y = y;
        w.frame_lines = lines;
        w.scanline = LINE_W'($urandom);
        w.rnd = rnd;
        pending_words.push_back(w);
    endfunction

    function automatic void push_read(input logic [LINE_W-1:0] line);
        trackball_word_t w;
        w = trackball_word_t'(WORD_W'({$urandom, $urandom}));
        w.cmd = CMD_READ;
        w.scanline = line;
        pending_words.push_back(w);
    endfunction

    function automatic logic [MOVE_W-1:0] pick_delta();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return MOVE_W'(int'($urandom_range(0, 24)) - 12);
        else if (sel == 6)
            return '0;
        else if (sel < 9)
            return MOVE_W'(int'($urandom_range(0, 400)) - 200);
        else
            return MOVE_W'($urandom);
    endfunction

    // frames: one motion word and a few reads at rising scanlines
    task automatic load_frames(input int n_items, input logic en);
        int count;
        int unsigned kind;
        int unsigned lines;
        int unsigned line;
        int unsigned reads;
        count = 0;
        while (count < n_items)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                lines = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(150, 320);
                push_motion(pick_delta(), pick_delta(), LINE_W'(lines), RND_W'($urandom));
                if (en)
                    count++;
                reads = $urandom_range(0, 6);
                line = $urandom_range(0, 20);
                for (int i = 0; i < reads; i++)
                begin
                    push_read(LINE_W'(line));
                    line = line + $urandom_range(0, lines / 3 + 2);
                    if (line > 1023)
                        line = 1023;
                    count++;
                end
            end
            else if (kind == 7)
            begin
                push_read(LINE_W'($urandom));
                count++;
            end
            else
            begin
                push_motion(MOVE_W'($urandom), MOVE_W'($urandom), LINE_W'($urandom),
                            RND_W'($urandom));
                if (en)
                    count++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == tps_pkg::REG_GAIN)
            gain_q = val[GAIN_W-1:0];
        else
            en_q = val[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // waits until nothing is queued or expected, then lets the block settle
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_phases.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [GAIN_W-1:0] g;
        logic              e;
        int                n;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 9; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    g = tps_pkg::GAIN_RESET; e = 1'b1; n = 0;
                end
                1:
                begin
                    g = tps_pkg::GAIN_RESET; e = 1'b1; n = 260;
                end
                2:
                begin
                    g = '0; e = 1'b1; n = 150;
                end
                3:
                begin
                    g = '1; e = 1'b1; n = 220;
                end
                4:
                begin
                    g = 16'd2048; e = 1'b1; n = 220;
                end
                5:
                begin
                    g = GAIN_W'($urandom); e = 1'b0; n = 60;
                end
                6:
                begin
                    g = GAIN_W'($urandom_range(1, 400)); e = 1'b1; n = 220;
                end
                7:
                begin
                    g = GAIN_W'($urandom); e = 1'b1; n = 250;
                end
                default:
                begin
                    g = tps_pkg::GAIN_RESET; e = 1'b1; n = 240;
                end
            endcase
            write_reg(tps_pkg::REG_GAIN, CFG_DATA_W'(g));
            write_reg(tps_pkg::REG_ENABLED, CFG_DATA_W'(e));
            if (ph == 0)
            begin
                // never marker straight after reset
                push_read(10'd1023);
                push_read(10'd0);
                // largest counts in both directions, step clamped to one line
                push_motion(12'h7FF, 12'h800, 10'd1023, 12'h000);
                push_read(10'd0);
                push_read(10'd1023);
                push_motion(12'h800, 12'h7FF, 10'd1023, 12'hFFF);
                push_read(10'd517);
                // zero counts push the offsets forward
                push_motion(12'h000, 12'h000, 10'd1023, 12'hFFF);
                push_motion(12'h000, 12'h000, 10'd1023, 12'hFFF);
                push_read(10'd1023);
                push_motion(12'h001, 12'hFFF, 10'd1023, 12'h000);
                push_read(10'd255);
                push_read(10'd256);
                push_read(10'd1023);
                // zero frame lines
                push_motion(12'h003, 12'h005, 10'd0, 12'h555);
                push_read(10'd1023);
                push_motion(12'hFFF, 12'h001, 10'd1, 12'hAAA);
                push_read(10'd1);
                push_motion(12'h005, 12'hFF9, 10'd1023, 12'h800);
                push_read(10'd300);
                push_read(10'd700);
                push_read(10'd1023);
            end
            else
            begin
                load_frames(n, e);
            end
        end
        wait_idle();
        if (expected_phases.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_phases.size()));
        $display("covered %0d motion words (%0d ignored while disabled), %0d reads checked,",
                 motion_words, ignored_words, read_words);
        $display("%0d phase steps, gains 0 to 65535 with enable off and on", phase_steps);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // sender: bursts of words with idle gaps in between
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !word_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                drive_word = pending_words.pop_front();
                s_tdata <= S_W'({drive_word.rnd, drive_word.scanline, drive_word.frame_lines,
                                 drive_word.move_y, drive_word.move_x});
                s_tuser <= drive_word.cmd;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: always ready, light stalls, heavy stalls, long stalls
    always @(negedge clk)
    begin
        ready_cnt++;
        case (ready_cnt[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_cnt[4:0] == 5'd0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken = s_tvalid && s_tready;
            if (word_taken)
            begin
                if (drive_word.cmd == CMD_READ)
                begin
                    phase_steps += advance_axis(tps_pkg::AXIS_H, drive_word.scanline);
                    phase_steps += advance_axis(tps_pkg::AXIS_V, drive_word.scanline);
                    expected_phases.push_back({dir_q[tps_pkg::AXIS_V], dir_q[tps_pkg::AXIS_H],
                                               phase_q[tps_pkg::AXIS_V],
                                               phase_q[tps_pkg::AXIS_H]});
                    read_words++;
                end
                else if (!en_q)
                begin
                    ignored_words++;
                end
                else
                begin
                    rescale_axis(tps_pkg::AXIS_H, longint'($signed(drive_word.move_x)),
                                 drive_word.frame_lines, drive_word.rnd);
                    rescale_axis(tps_pkg::AXIS_V, -longint'($signed(drive_word.move_y)),
                                 drive_word.frame_lines, drive_word.rnd);
                    motion_words++;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_phases.size() == 0)
                begin
                    report_mismatch($sformatf("output word %h with nothing expected", m_tdata));
                end
                else
                begin
                    want = expected_phases.pop_front();
                    if (m_tdata[1:0] !== want[1:0])
                        report_mismatch($sformatf("phase_h %0d, expected %0d",
                                                  m_tdata[1:0], want[1:0]));
                    if (m_tdata[3:2] !== want[3:2])
                        report_mismatch($sformatf("phase_v %0d, expected %0d",
                                                  m_tdata[3:2], want[3:2]));
                    if (m_tdata[4] !== want[4])
                        report_mismatch($sformatf("moving_left %b, expected %b",
                                                  m_tdata[4], want[4]));
                    if (m_tdata[5] !== want[5])
                        report_mismatch($sformatf("moving_down %b, expected %b",
                                                  m_tdata[5], want[5]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit, %0d words still queued",
                     pending_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

/* files.f */
+incdir+hdl
hdl/tps_pkg.sv
hdl/tps_ctrl.sv
hdl/tps_dp.sv
hdl/trackball_phase_scheduler_top.sv
sim/tb_trackball_phase_scheduler_top.sv
